// ===== rtl/core/md5_pkg.sv =====
// md5_pkg: shared constants, types and tables for the md5 message digest core
// no dependencies
`timescale 1ns / 1ps

package md5_pkg;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned WordW    = 32;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;

  // byte source selection for the buffer write port
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       buf_we;      // write one byte into the block buffer
    logic [5:0] buf_waddr;
    logic [1:0] buf_src;
    logic [2:0] len_sel;     // byte of the latched length
    logic       cnt_inc;     // count one message byte
    logic       len_latch;   // freeze bit count for the trailer
    logic       rnd_load;    // copy chain words into working registers
    logic       rnd_step;    // run one compression step
    logic [5:0] rnd_idx;
    logic [3:0] rd_word;     // buffer word read for the next step
    logic       rd_en;
    logic       chain_add;   // fold working registers into chain words
    logic       chain_init;  // reload initial constants and clear count
  } md5_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] fill;        // buffer fill level from bit count
  } md5_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    begin
      unique case ({i[5:4], i[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // message word used by step i
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    begin
      unique case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: g = 4'(5 * i[3:0] + 1);
        2'd2: g = 4'(3 * i[3:0] + 5);
        default: g = 4'(7 * i[3:0]);
      endcase
      return g;
    end
  endfunction

endpackage

// ===== rtl/core/md5_ram.sv =====
// md5_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module md5_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/core/md5_datapath.sv =====
// md5_datapath: block buffer, bit count, chain words and one-step compression round
// depends on md5_pkg and md5_ram
`timescale 1ns / 1ps

module md5_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::md5_cmd_t   cmd,
  input  logic [7:0]          in_byte,
  output md5_pkg::md5_sts_t   sts,
  output logic [127:0]        chain
);

  logic [63:0] cnt_r, len_r;
  logic [31:0] h0_r, h1_r, h2_r, h3_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [7:0]  wbyte;
  logic [31:0] word;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  // four byte lanes make one little-endian 32-bit word per read
  genvar gl;
  generate
    for (gl = 0; gl < 4; gl++) begin : g_lane
      md5_ram #(.Width(8), .Depth(md5_pkg::BufDepth / 4)) u_lane (
        .clk   (clk),
        .we    (cmd.buf_we && (cmd.buf_waddr[1:0] == 2'(gl))),
        .waddr (cmd.buf_waddr[5:2]),
        .wdata (wbyte),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_word),
        .rdata (word[8*gl +: 8])
      );
    end
  endgenerate

  // byte source for the buffer write
  always_comb begin
    case (cmd.buf_src)
      md5_pkg::SRC_DATA: wbyte = in_byte;
      md5_pkg::SRC_PAD:  wbyte = md5_pkg::PadByte;
      md5_pkg::SRC_ZERO: wbyte = 8'h00;
      default:           wbyte = len_r[8*cmd.len_sel +: 8];
    endcase
  end

  // round function for the current step
  always_comb begin
    case (cmd.rnd_idx[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s   = md5_pkg::rot_amt(cmd.rnd_idx);
    sum = a_r + f + md5_pkg::round_k(cmd.rnd_idx) + word;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // bit count and trailer length
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_init) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 64'd8;
    end
    if (cmd.len_latch) begin
      len_r <= cnt_r;
    end
  end

  // chain words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_init) begin
      h0_r <= md5_pkg::InitA;
      h1_r <= md5_pkg::InitB;
      h2_r <= md5_pkg::InitC;
      h3_r <= md5_pkg::InitD;
    end else if (cmd.chain_add) begin
      h0_r <= h0_r + a_r;
      h1_r <= h1_r + b_r;
      h2_r <= h2_r + c_r;
      h3_r <= h3_r + d_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.rnd_load) begin
      a_r <= h0_r;
      b_r <= h1_r;
      c_r <= h2_r;
      d_r <= h3_r;
    end else if (cmd.rnd_step) begin
      a_r <= d_r;
      b_r <= b_r + rot;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  assign sts.fill = cnt_r[8:3];
  assign chain    = {h3_r, h2_r, h1_r, h0_r};

endmodule

// ===== rtl/core/md5_ctrl.sv =====
// md5_ctrl: sequencer for byte loads, padding, 64-step compression and digest output
// depends on md5_pkg
`timescale 1ns / 1ps

module md5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              has_byte,
  input  logic              is_last,
  input  logic              out_tready,
  input  md5_pkg::md5_sts_t sts,
  output md5_pkg::md5_cmd_t cmd,
  output logic              in_tready,
  output logic              out_tvalid,
  output logic [1:0]        out_idx
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;  // first buffer read in flight
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic [5:0] pos_r, pos_nxt;     // padding write position
  logic       fin_r, fin_nxt;     // block belongs to the padding
  logic       lenb_r, lenb_nxt;   // trailer placed in this block
  logic       mark_r, mark_nxt;   // 0x80 pad byte already placed
  logic [1:0] oidx_r, oidx_nxt;
  logic [5:0] nstep;

  assign nstep = step_r + 6'd1;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pos_nxt   = pos_r;
    fin_nxt   = fin_r;
    lenb_nxt  = lenb_r;
    mark_nxt  = mark_r;
    oidx_nxt  = oidx_r;
    cmd       = '0;
    cmd.rd_word = md5_pkg::msg_idx(step_r);
    cmd.rnd_idx = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.buf_waddr = sts.fill;
          cmd.buf_src   = md5_pkg::SRC_DATA;
          cmd.buf_we    = has_byte;
          cmd.cnt_inc   = has_byte;
          pos_nxt       = has_byte ? sts.fill + 6'd1 : sts.fill;
          fin_nxt       = is_last;
          lenb_nxt      = 1'b0;
          mark_nxt      = 1'b0;
          if (is_last) begin
            state_nxt = ST_PAD;
            pos_nxt   = pos_nxt;
          end
          if (has_byte && sts.fill == 6'd63) begin
            step_nxt  = '0;
            state_nxt = ST_PRE;
          end
        end
      end
      ST_PAD: begin
        // first pad byte 0x80, then zeros, then the eight length bytes
        if (pos_r == 6'd0 && fin_r && !lenb_r && step_r == 6'd63) begin
          cmd.buf_src = md5_pkg::SRC_ZERO;
        end
        cmd.buf_we    = 1'b1;
        cmd.buf_waddr = pos_r;
        if (step_r != 6'd63) begin
          cmd.len_latch = 1'b1;
          cmd.buf_src   = md5_pkg::SRC_PAD;
          step_nxt      = 6'd63;
          mark_nxt      = 1'b1;
        end else if (pos_r >= 6'd56 && lenb_r) begin
          cmd.buf_src = md5_pkg::SRC_LEN;
          cmd.len_sel = 3'(pos_r - 6'd56);
        end else begin
          cmd.buf_src = md5_pkg::SRC_ZERO;
        end
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd55 && step_r != 6'd63) begin
          lenb_nxt = 1'b1;
        end else if (pos_r == 6'd55) begin
          lenb_nxt = 1'b1;
        end
        if (pos_r == 6'd63) begin
          step_nxt  = '0;
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.rd_en    = 1'b1;
        cmd.rnd_load = 1'b1;
        state_nxt    = ST_RND;
      end
      ST_RND: begin
        cmd.rnd_step = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_word  = md5_pkg::msg_idx(nstep);
        step_nxt     = nstep;
        if (step_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        step_nxt      = '0;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (lenb_r) begin
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          // last byte filled the block: the 0x80 is still due; else only the length
          if (mark_r) begin
            step_nxt = 6'd63;
          end
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            cmd.chain_init = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
      lenb_r  <= 1'b0;
      mark_r  <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
      lenb_r  <= lenb_nxt;
      mark_r  <= mark_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_idx    = oidx_r;

endmodule

// ===== rtl/core/md5_message_digest.sv =====
// md5_message_digest: top level of the md5 digest core
// depends on md5_pkg, md5_ctrl and md5_datapath
`timescale 1ns / 1ps
//
// Usage
//   in_* takes one item per transfer: a message byte (when has_byte is set)
//   and an end-of-message flag on in_tlast. A message may be empty.
//   out_* gives the four digest words h0..h3 after the last item, low byte
//   of each word first as a byte string; out_tlast marks h3.
// Timing
//   a byte that does not fill the buffer is written and input stays open;
//   the 64th byte of a block starts a compression (one buffer read, 64 steps
//   of the single round unit, one chain add) during which no input is taken.
//   The last item adds 9 to 72 padding writes and one or two compressions,
//   then the four words go out one per cycle while out_tready is high.
// Reset
//   rst_n reloads the initial chain words and clears the bit count.
// Stall
//   while out_tready is low the current digest word holds; no input is taken
//   until all four words have been transferred.
//

module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word, word_index, zero fill
  output logic        out_tlast   // last_word
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;
  logic [127:0]      chain;
  logic [1:0]        idx;
  logic              in_fire;

  assign in_fire = in_tvalid && in_tready;

  md5_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .has_byte   (in_tuser),
    .is_last    (in_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_idx    (idx)
  );

  md5_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_tdata),
    .sts     (sts),
    .chain   (chain)
  );

  // digest word selection
  assign out_tdata = {6'd0, idx, chain[32*idx +: 32]};
  assign out_tlast = (idx == 2'd3);

`ifndef SYNTHESIS
  // no input while a digest is being delivered
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open during digest");
  // stalled digest word holds its index
  a_hold_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(idx)) else $error("index moved");
  // a final word ends the output burst
  a_end_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid) else $error("extra word");
`endif

endmodule
